// ===== sv/vaf2d_pkg.sv =====
// vaf2d_pkg: shared constants for the 2d vertex affine transform core
// mode codes, register indexes, fixed field widths and the diagonal constant
// no dependencies
package vaf2d_pkg;

  localparam int COORD_WIDTH_DEF = 16;

  localparam int MODE_W   = 4;
  localparam int OFFSET_W = 16;
  localparam int FACTOR_W = 9;
  localparam int TRIG_W   = 16;

  // rotation fraction bits and cos/sin of 45 degrees in q2.14
  localparam int Q_SHIFT = 14;
  localparam int DIAG_CS = 11585;

  localparam int APB_AW = 5;
  localparam int APB_DW = 32;

  localparam logic [MODE_W-1:0] MODE_TRANSLATE    = 4'd0;
  localparam logic [MODE_W-1:0] MODE_SCALE        = 4'd1;
  localparam logic [MODE_W-1:0] MODE_REFLECT_X    = 4'd2;
  localparam logic [MODE_W-1:0] MODE_REFLECT_Y    = 4'd3;
  localparam logic [MODE_W-1:0] MODE_DIAG         = 4'd4;
  localparam logic [MODE_W-1:0] MODE_SHEAR        = 4'd5;
  localparam logic [MODE_W-1:0] MODE_ROTATE       = 4'd6;
  localparam logic [MODE_W-1:0] MODE_PIVOT_ROTATE = 4'd7;
  localparam logic [MODE_W-1:0] MODE_PIVOT_SCALE  = 4'd8;

  localparam logic [2:0] REG_MODE     = 3'd0;
  localparam logic [2:0] REG_OFFSET_X = 3'd1;
  localparam logic [2:0] REG_OFFSET_Y = 3'd2;
  localparam logic [2:0] REG_FACTOR_X = 3'd3;
  localparam logic [2:0] REG_FACTOR_Y = 3'd4;
  localparam logic [2:0] REG_COS      = 3'd5;
  localparam logic [2:0] REG_SIN      = 3'd6;

endpackage

// ===== sv/vaf2d_in_if.sv =====
// vaf2d_in_if: vertex request channel, valid/ready with the input coordinates
// depends on vaf2d_pkg
interface vaf2d_in_if import vaf2d_pkg::*; #(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF
);
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] in_x;
  logic signed [COORD_WIDTH-1:0] in_y;

  modport source (output valid, in_x, in_y, input ready);
  modport sink   (input valid, in_x, in_y, output ready);
endinterface

// ===== sv/vaf2d_out_if.sv =====
// vaf2d_out_if: result channel, valid/ready with transformed coordinates and flag
// depends on vaf2d_pkg
interface vaf2d_out_if import vaf2d_pkg::*; #(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF
);
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] out_x;
  logic signed [COORD_WIDTH-1:0] out_y;
  logic                          overflow;

  modport source (output valid, out_x, out_y, overflow, input ready);
  modport sink   (input valid, out_x, out_y, overflow, output ready);
endinterface

// ===== sv/vertex_affine_transform_2d_core.sv =====
// Eight-stage pipeline: one vertex request is taken per cycle while the output
// is not stalled. Each stage holds its own valid bit and loads whenever it is
// empty or the stage after it moves on, so a stall at the result side fills the
// pipeline one stage at a time and bubbles are squeezed out; the input keeps
// accepting as long as any stage ahead has room. Stages: pivot subtract, 2x2
// matrix products, product sums, q2.14 truncation toward zero, second rotation
// products (diagonal mode), their sums, truncation and select, then offset add
// with saturation into the output register. Configuration goes through the apb
// port; the user must write it only while idle, the core does not enforce it.
// depends on vaf2d_pkg, vaf2d_in_if, vaf2d_out_if
module vertex_affine_transform_2d_core import vaf2d_pkg::*; #(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
  input  logic              clk,
  input  logic              rst,
  vaf2d_in_if.sink          in_ch,
  vaf2d_out_if.source       out_ch,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready
);

  localparam int CW = COORD_WIDTH;
  localparam int MW = ((CW > OFFSET_W) ? CW : OFFSET_W) + 1; // after pivot subtract
  localparam int KW = TRIG_W + 1;                            // coefficient, holds -sin
  localparam int PW = MW + KW;
  localparam int SW = PW + 1;
  localparam int DW = CW + 1;                                // diagonal pass input
  localparam int QW = DW + 16;
  localparam int RW = QW + 1;
  localparam int FW = SW + 1;
  localparam int NST = 8;

  localparam logic signed [KW-1:0] K_ONE  = KW'(1);
  localparam logic signed [KW-1:0] K_MONE = {KW{1'b1}};
  localparam logic signed [KW-1:0] K_DIAG = KW'(DIAG_CS);
  localparam logic signed [QW-1:0] Q_DIAG = QW'(DIAG_CS);
  localparam logic signed [CW-1:0] C_MAX  = {1'b0, {(CW-1){1'b1}}};
  localparam logic signed [CW-1:0] C_MIN  = {1'b1, {(CW-1){1'b0}}};

  // configuration registers
  logic        [MODE_W-1:0]   mode;
  logic signed [OFFSET_W-1:0] offset_x;
  logic signed [OFFSET_W-1:0] offset_y;
  logic signed [FACTOR_W-1:0] factor_x;
  logic signed [FACTOR_W-1:0] factor_y;
  logic signed [TRIG_W-1:0]   cos_value;
  logic signed [TRIG_W-1:0]   sin_value;

  logic       cfg_write;
  logic [2:0] cfg_index;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;
  assign cfg_index = paddr[4:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      mode      <= MODE_TRANSLATE;
      offset_x  <= '0;
      offset_y  <= '0;
      factor_x  <= FACTOR_W'(1);
      factor_y  <= FACTOR_W'(1);
      cos_value <= TRIG_W'(1 << Q_SHIFT);
      sin_value <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_MODE:     mode      <= pwdata[MODE_W-1:0];
        REG_OFFSET_X: offset_x  <= pwdata[OFFSET_W-1:0];
        REG_OFFSET_Y: offset_y  <= pwdata[OFFSET_W-1:0];
        REG_FACTOR_X: factor_x  <= pwdata[FACTOR_W-1:0];
        REG_FACTOR_Y: factor_y  <= pwdata[FACTOR_W-1:0];
        REG_COS:      cos_value <= pwdata[TRIG_W-1:0];
        REG_SIN:      sin_value <= pwdata[TRIG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_index)
      REG_MODE:     prdata = APB_DW'(mode);
      REG_OFFSET_X: prdata = APB_DW'(offset_x);
      REG_OFFSET_Y: prdata = APB_DW'(offset_y);
      REG_FACTOR_X: prdata = APB_DW'(factor_x);
      REG_FACTOR_Y: prdata = APB_DW'(factor_y);
      REG_COS:      prdata = APB_DW'(cos_value);
      REG_SIN:      prdata = APB_DW'(sin_value);
      default:      prdata = '0;
    endcase
  end

  // mode decode
  logic pivot_mode, offset_mode, shift_mode, diag_mode;

  assign pivot_mode  = (mode == MODE_PIVOT_ROTATE) || (mode == MODE_PIVOT_SCALE);
  assign offset_mode = pivot_mode || (mode == MODE_TRANSLATE);
  assign shift_mode  = (mode == MODE_ROTATE) || (mode == MODE_PIVOT_ROTATE) ||
                       (mode == MODE_DIAG);
  assign diag_mode   = (mode == MODE_DIAG);

  // per-stage valid and load enables
  logic [NST:1] vld;
  logic [NST:1] rdy;

  always_comb begin
    rdy[NST] = !vld[NST] || out_ch.ready;
    for (int i = NST - 1; i >= 1; i--) begin
      rdy[i] = !vld[i] || rdy[i+1];
    end
  end

  assign in_ch.ready = rdy[1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (rdy[1]) begin
        vld[1] <= in_ch.valid;
      end
      for (int i = 2; i <= NST; i++) begin
        if (rdy[i]) begin
          vld[i] <= vld[i-1];
        end
      end
    end
  end

  // stage 1: pivot subtract
  logic signed [MW-1:0] a1, b1;

  always_ff @(posedge clk) begin
    if (rdy[1]) begin
      a1 <= MW'(in_ch.in_x) - (pivot_mode ? MW'(offset_x) : MW'(0));
      b1 <= MW'(in_ch.in_y) - (pivot_mode ? MW'(offset_y) : MW'(0));
    end
  end

  // stage 2: 2x2 matrix products
  logic signed [KW-1:0] k00, k01, k10, k11;
  logic signed [PW-1:0] p00, p01, p10, p11;

  always_comb begin
    k00 = K_ONE;
    k01 = '0;
    k10 = '0;
    k11 = K_ONE;
    case (mode)
      MODE_SCALE, MODE_PIVOT_SCALE: begin
        k00 = KW'(factor_x);
        k11 = KW'(factor_y);
      end
      MODE_REFLECT_X: k11 = K_MONE;
      MODE_REFLECT_Y: k00 = K_MONE;
      MODE_DIAG: begin
        // rotate by -45 degrees
        k00 = K_DIAG;
        k01 = K_DIAG;
        k10 = -K_DIAG;
        k11 = K_DIAG;
      end
      MODE_SHEAR: begin
        k01 = KW'(factor_x);
        k10 = KW'(factor_y);
      end
      MODE_ROTATE, MODE_PIVOT_ROTATE: begin
        k00 = KW'(cos_value);
        k01 = -KW'(sin_value);
        k10 = KW'(sin_value);
        k11 = KW'(cos_value);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rdy[2]) begin
      p00 <= PW'(a1) * PW'(k00);
      p01 <= PW'(b1) * PW'(k01);
      p10 <= PW'(a1) * PW'(k10);
      p11 <= PW'(b1) * PW'(k11);
    end
  end

  // stage 3: product sums
  logic signed [SW-1:0] sx3, sy3;

  always_ff @(posedge clk) begin
    if (rdy[3]) begin
      sx3 <= SW'(p00) + SW'(p01);
      sy3 <= SW'(p10) + SW'(p11);
    end
  end

  // stage 4: divide by 2^14 rounding toward zero where the mode rotates
  logic signed [SW-1:0] bx3, by3, tx3, ty3;
  logic signed [SW-1:0] x4, y4;

  assign bx3 = {{(SW-Q_SHIFT){1'b0}}, {Q_SHIFT{sx3[SW-1]}}};
  assign by3 = {{(SW-Q_SHIFT){1'b0}}, {Q_SHIFT{sy3[SW-1]}}};
  assign tx3 = (sx3 + bx3) >>> Q_SHIFT;
  assign ty3 = (sy3 + by3) >>> Q_SHIFT;

  always_ff @(posedge clk) begin
    if (rdy[4]) begin
      x4 <= shift_mode ? tx3 : sx3;
      y4 <= shift_mode ? ty3 : sy3;
    end
  end

  // stage 5: products of the +45 rotation, only meaningful in diagonal mode
  logic signed [DW-1:0] xn4, yn4;
  logic signed [SW-1:0] x5, y5;
  logic signed [QW-1:0] q0, q1;

  assign xn4 = x4[DW-1:0];
  assign yn4 = y4[DW-1:0];

  always_ff @(posedge clk) begin
    if (rdy[5]) begin
      x5 <= x4;
      y5 <= y4;
      q0 <= QW'(xn4) * Q_DIAG;
      q1 <= QW'(yn4) * Q_DIAG;
    end
  end

  // stage 6: sums with x negated between the two rotations
  logic signed [SW-1:0] x6, y6;
  logic signed [RW-1:0] sx6, sy6;

  always_ff @(posedge clk) begin
    if (rdy[6]) begin
      x6  <= x5;
      y6  <= y5;
      sx6 <= -(RW'(q0) + RW'(q1));
      sy6 <= RW'(q1) - RW'(q0);
    end
  end

  // stage 7: truncate the second rotation and select
  logic signed [RW-1:0] bx6, by6, tx6, ty6;
  logic signed [SW-1:0] x7, y7;

  assign bx6 = {{(RW-Q_SHIFT){1'b0}}, {Q_SHIFT{sx6[RW-1]}}};
  assign by6 = {{(RW-Q_SHIFT){1'b0}}, {Q_SHIFT{sy6[RW-1]}}};
  assign tx6 = (sx6 + bx6) >>> Q_SHIFT;
  assign ty6 = (sy6 + by6) >>> Q_SHIFT;

  always_ff @(posedge clk) begin
    if (rdy[7]) begin
      x7 <= diag_mode ? SW'(tx6) : x6;
      y7 <= diag_mode ? SW'(ty6) : y6;
    end
  end

  // stage 8: offset add and saturation into the output register
  logic signed [FW-1:0] fx7, fy7;
  logic                 ovx, ovy;
  logic signed [CW-1:0] sat_x, sat_y;
  logic                 sat_ovf;

  assign fx7 = FW'(x7) + (offset_mode ? FW'(offset_x) : FW'(0));
  assign fy7 = FW'(y7) + (offset_mode ? FW'(offset_y) : FW'(0));
  // out of range when the result sign bit and the bits above it disagree
  assign ovx = !((&fx7[FW-1:CW-1]) || !(|fx7[FW-1:CW-1]));
  assign ovy = !((&fy7[FW-1:CW-1]) || !(|fy7[FW-1:CW-1]));

  always_ff @(posedge clk) begin
    if (rdy[8]) begin
      sat_x   <= ovx ? (fx7[FW-1] ? C_MIN : C_MAX) : fx7[CW-1:0];
      sat_y   <= ovy ? (fy7[FW-1] ? C_MIN : C_MAX) : fy7[CW-1:0];
      sat_ovf <= ovx || ovy;
    end
  end

  assign out_ch.valid    = vld[NST];
  assign out_ch.out_x    = sat_x;
  assign out_ch.out_y    = sat_y;
  assign out_ch.overflow = sat_ovf;

  // an empty output register means the whole pipeline can move
  a_ready_when_out_empty: assert property (@(posedge clk) disable iff (rst)
    !vld[NST] |-> in_ch.ready)
    else $error("input stalled with an empty output register");

  // an item that leaves stage 1 shows up in stage 2
  a_stage_advance: assert property (@(posedge clk) disable iff (rst)
    vld[1] && rdy[2] |=> vld[2])
    else $error("item lost between stage 1 and stage 2");

  // the flag only comes with a clamped coordinate
  a_overflow_clamped: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && out_ch.overflow |->
      (sat_x == C_MAX) || (sat_x == C_MIN) || (sat_y == C_MAX) || (sat_y == C_MIN))
    else $error("overflow flag without a saturated coordinate");

endmodule
